>>> design/wildcard_byte_pattern_search_assert.svh
// Assertion macros for the wildcard byte pattern search checker.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH

// Consequent must hold in the same cycle.
`define WBPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the next cycle.
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`define WBPS_ASSERT_LATER(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

>>> design/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

  localparam int PAT_REG_BYTES = 16;
  localparam int OFFSET_OUT_W  = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int LEN_W         = 5;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;

  localparam logic [15:0] CARE_MASK_RESET = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_end;
  } in_item_t;

  typedef struct packed {
    logic                    match_found;
    logic [OFFSET_OUT_W-1:0] match_offset;
    logic                    region_done;
  } out_item_t;

  typedef struct packed {
    logic [63:0]      pattern_low;
    logic [63:0]      pattern_high;
    logic [15:0]      care_mask;
    logic [LEN_W-1:0] pattern_length;
  } cfg_regs_t;

endpackage

`default_nettype wire

>>> design/wildcard_byte_pattern_search.sv
// Wildcard byte pattern search.
// Input channel (in_valid/in_ready/in_item) takes one byte of a memory region
// per item, with region_end marking the region's last byte. The result
// channel (out_valid/out_ready/out_item) returns exactly one item per input
// byte: match_found, match_offset (start offset of the pattern in the region)
// and region_done. Configuration (cfg_we/cfg_index/cfg_wdata) loads the
// pattern bytes, care mask and pattern length; it is to be written only
// while the block is idle, and the block itself does not enforce this.
// Pipeline: an accepted byte is registered in the window/position stage,
// then its result in the compare-and-result stage, which drives out_valid.
// Throughput: one byte per cycle while the result stage drains; all pattern
// bytes are compared in parallel against the window register.
// Reset clears the window, the region position, the pipeline valid bits and
// the configuration (care mask all ones, pattern length zero).
// When out_ready is low the result register holds its item; the window stage
// still holds one more item, and in_ready drops only when both are full.
`default_nettype none

module wildcard_byte_pattern_search #(
  parameter int MAX_PATTERN  = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire wbps_pkg::in_item_t                 in_item,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output wbps_pkg::out_item_t                     out_item,
  input  wire logic                               cfg_we,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  wbps_pkg::cfg_regs_t         regs;
  logic                        adv;
  logic                        stg_vld;
  logic                        stg_end;
  logic [OFFSET_WIDTH-1:0]     stg_count;
  logic [MAX_PATTERN-1:0][7:0] stg_win;

  wbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  wbps_window #(
    .MAX_PATTERN  (MAX_PATTERN),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .adv       (adv),
    .stg_vld   (stg_vld),
    .stg_end   (stg_end),
    .stg_count (stg_count),
    .stg_win   (stg_win)
  );

  wbps_match #(
    .MAX_PATTERN  (MAX_PATTERN),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .regs      (regs),
    .stg_vld   (stg_vld),
    .stg_end   (stg_end),
    .stg_count (stg_count),
    .stg_win   (stg_win),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> design/wbps_cfg.sv
`default_nettype none

module wbps_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output wbps_pkg::cfg_regs_t                     regs
);

  wbps_pkg::cfg_regs_t regs_r;
  wbps_pkg::cfg_regs_t regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::REG_PATTERN_LOW:    regs_nxt.pattern_low    = cfg_wdata;
        wbps_pkg::REG_PATTERN_HIGH:   regs_nxt.pattern_high   = cfg_wdata;
        wbps_pkg::REG_CARE_MASK:      regs_nxt.care_mask      = cfg_wdata[15:0];
        wbps_pkg::REG_PATTERN_LENGTH:
          regs_nxt.pattern_length = cfg_wdata[wbps_pkg::LEN_W-1:0];
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.pattern_low    <= '0;
      regs_r.pattern_high   <= '0;
      regs_r.care_mask      <= wbps_pkg::CARE_MASK_RESET;
      regs_r.pattern_length <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

>>> design/wbps_window.sv
`default_nettype none

module wbps_window #(
  parameter int MAX_PATTERN  = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire wbps_pkg::in_item_t                 in_item,
  input  wire logic                               adv,
  output logic                                    stg_vld,
  output logic                                    stg_end,
  output logic [OFFSET_WIDTH-1:0]                 stg_count,
  output logic [MAX_PATTERN-1:0][7:0]             stg_win
);

  logic [MAX_PATTERN-1:0][7:0] win_r;
  logic [MAX_PATTERN-1:0][7:0] win_nxt;
  logic [OFFSET_WIDTH-1:0]     pos_r;
  logic [OFFSET_WIDTH-1:0]     count_r;
  logic [OFFSET_WIDTH-1:0]     count_nxt;
  logic                        vld_r;
  logic                        end_r;
  logic                        take;

  assign in_ready = !vld_r || adv;
  assign take     = in_valid && in_ready;

  // saturate at the top count
  assign count_nxt = (&pos_r) ? pos_r : pos_r + OFFSET_WIDTH'(1);

  always_comb begin
    win_nxt[0] = in_item.data_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      pos_r <= '0;
      win_r <= '0;
    end else begin
      if (take) begin
        vld_r <= 1'b1;
        pos_r <= in_item.region_end ? '0 : count_nxt;
        win_r <= win_nxt;
      end else if (adv) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      count_r <= count_nxt;
      end_r   <= in_item.region_end;
    end
  end

  assign stg_vld   = vld_r;
  assign stg_end   = end_r;
  assign stg_count = count_r;
  assign stg_win   = win_r;

endmodule

`default_nettype wire

>>> design/wbps_match.sv
`default_nettype none

module wbps_match #(
  parameter int MAX_PATTERN  = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire wbps_pkg::cfg_regs_t                regs,
  input  wire logic                               stg_vld,
  input  wire logic                               stg_end,
  input  wire logic [OFFSET_WIDTH-1:0]            stg_count,
  input  wire logic [MAX_PATTERN-1:0][7:0]        stg_win,
  output logic                                    adv,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output wbps_pkg::out_item_t                     out_item
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int EXT_W = (OFFSET_WIDTH > wbps_pkg::OFFSET_OUT_W) ?
                         OFFSET_WIDTH : wbps_pkg::OFFSET_OUT_W;

  logic [MAX_PATTERN-1:0]                 byte_ok;
  logic [8*wbps_pkg::PAT_REG_BYTES-1:0]   pat_all;
  logic [6:0]                             len7;
  logic                                   len_ok;
  logic                                   hit;
  logic [OFFSET_WIDTH-1:0]                diff;
  logic [EXT_W-1:0]                       diff_ext;
  wbps_pkg::out_item_t                    res;
  wbps_pkg::out_item_t                    item_r;
  logic                                   vld_r;

  assign pat_all = {regs.pattern_high, regs.pattern_low};
  assign len7    = 7'(regs.pattern_length);

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
    if (j < wbps_pkg::PAT_REG_BYTES) begin : g_reg
      logic [6:0] sel;
      logic [7:0] wb;
      // pattern byte j lines up with window entry len-1-j (newest first)
      assign sel        = len7 - 7'd1 - 7'(j);
      assign wb         = stg_win[sel[IDX_W-1:0]];
      assign byte_ok[j] = (7'(j) >= len7) || !regs.care_mask[j] ||
                          (wb == pat_all[8*j +: 8]);
    end else begin : g_wild
      assign byte_ok[j] = 1'b1;
    end
  end

  assign len_ok = (len7 != 7'd0) && (len7 <= 7'(MAX_PATTERN)) &&
                  (stg_count >= OFFSET_WIDTH'(regs.pattern_length));
  assign hit      = len_ok && (&byte_ok);
  assign diff     = stg_count - OFFSET_WIDTH'(regs.pattern_length);
  assign diff_ext = EXT_W'(diff);

  always_comb begin
    res.match_found  = hit;
    res.match_offset = hit ? diff_ext[wbps_pkg::OFFSET_OUT_W-1:0] : '0;
    res.region_done  = stg_end;
  end

  assign adv = stg_vld && (!vld_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

>>> design/wbps_checker.sv
`default_nettype none

module wbps_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire wbps_pkg::out_item_t out_item
);

`include "wildcard_byte_pattern_search_assert.svh"

  `WBPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_item), "stalled result item changed")
  `WBPS_ASSERT_NOW(a_nomatch_zero, out_valid && !out_item.match_found,
                   out_item.match_offset == '0, "offset nonzero without match")
  `WBPS_ASSERT_LATER(a_result_due, in_valid && in_ready, out_valid,
                     "no result two cycles after accept")
  `WBPS_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready,
                   "input stalled without output backpressure")

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

>>> tb/wildcard_byte_pattern_search_tb.sv
`timescale 1ns / 100ps

module wildcard_byte_pattern_search_tb;

  localparam int IDLE_PCT = 19;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_SLACK = 4;
  localparam int RANDOM_PHASES = 11;
  localparam logic [wbps_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int CFG_RESET = 0;
  localparam int CFG_GAP_PATTERN = 1;
  localparam int CFG_ANY_BYTE = 2;
  localparam int CFG_TOO_LONG = 3;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] care;
    logic [63:0] len;
  } cfg_set_t;

  typedef struct {
    logic [7:0]          data;
    logic                last;
    int                  cfg_sel;
    logic                fixed;
    wbps_pkg::out_item_t want;
  } directed_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  wbps_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wbps_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic no_idle = 1'b0;
  int stall_requests = 0;
  int stalls_served = 0;
  int failures = 0;

  logic [127:0] pat_bytes = '0;
  logic [15:0] care_bits = wbps_pkg::CARE_MASK_RESET;
  logic [wbps_pkg::LEN_W-1:0] pat_len = '0;
  logic [7:0] window [16];
  logic [31:0] region_pos = '0;
  wbps_pkg::out_item_t expected_matches [$];

  cfg_set_t directed_cfgs [4] = '{
    '{64'h0, 64'h0, 64'hFFFF, 64'h0},
    '{64'h0000_0000_4400_4241, 64'h0, 64'hFFFB, 64'd4},
    '{'1, '1, 64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFE1},
    '{64'h0, 64'h0, 64'h0, 64'd17}
  };

  directed_row_t directed_rows [19] = '{
    '{8'h00, 1'b0, CFG_RESET, 1'b1, '{1'b0, 32'd0, 1'b0}},
    '{8'hFF, 1'b1, CFG_RESET, 1'b1, '{1'b0, 32'd0, 1'b1}},
    '{8'h41, 1'b0, CFG_GAP_PATTERN, 1'b0, '0},
    '{8'h42, 1'b0, CFG_GAP_PATTERN, 1'b0, '0},
    '{8'hFF, 1'b0, CFG_GAP_PATTERN, 1'b0, '0},
    '{8'h44, 1'b0, CFG_GAP_PATTERN, 1'b0, '0},
    '{8'h41, 1'b0, CFG_GAP_PATTERN, 1'b0, '0},
    '{8'h42, 1'b0, CFG_GAP_PATTERN, 1'b0, '0},
    '{8'h00, 1'b0, CFG_GAP_PATTERN, 1'b0, '0},
    '{8'h44, 1'b0, CFG_GAP_PATTERN, 1'b0, '0},
    '{8'h41, 1'b0, CFG_GAP_PATTERN, 1'b0, '0},
    '{8'h42, 1'b1, CFG_GAP_PATTERN, 1'b0, '0},
    '{8'h00, 1'b0, CFG_GAP_PATTERN, 1'b0, '0},
    '{8'h44, 1'b1, CFG_GAP_PATTERN, 1'b0, '0},
    '{8'h00, 1'b0, CFG_ANY_BYTE, 1'b1, '{1'b1, 32'd0, 1'b0}},
    '{8'hFF, 1'b0, CFG_ANY_BYTE, 1'b1, '{1'b1, 32'd1, 1'b0}},
    '{8'h7E, 1'b1, CFG_ANY_BYTE, 1'b1, '{1'b1, 32'd2, 1'b1}},
    '{8'h41, 1'b0, CFG_TOO_LONG, 1'b1, '{1'b0, 32'd0, 1'b0}},
    '{8'hFF, 1'b1, CFG_TOO_LONG, 1'b1, '{1'b0, 32'd0, 1'b1}}
  };

  wildcard_byte_pattern_search DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("wildcard_byte_pattern_search_tb NOT OK");
    $finish;
  end

  initial begin
    foreach (window[k]) window[k] = '0;
  end

  function automatic wbps_pkg::out_item_t scan_byte(wbps_pkg::in_item_t item);
    wbps_pkg::out_item_t r;
    logic [31:0] count;
    logic hit;
    int len;
    for (int k = 15; k > 0; k--) window[k] = window[k-1];
    window[0] = item.data_byte;
    count = region_pos;
    if (count != '1) count++;
    len = int'(pat_len);
    hit = 1'b0;
    if (len >= 1 && len <= 16 && count >= 32'(len)) begin
      hit = 1'b1;
      for (int j = 0; j < len; j++) begin
        if (care_bits[j] && window[len-1-j] != pat_bytes[8*j +: 8]) hit = 1'b0;
      end
    end
    region_pos = item.region_end ? '0 : count;
    r.match_found = hit;
    r.match_offset = hit ? count - 32'(len) : '0;
    r.region_done = item.region_end;
    return r;
  endfunction

  task automatic cfg_write(input logic [wbps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      wbps_pkg::REG_PATTERN_LOW: pat_bytes[63:0] = data;
      wbps_pkg::REG_PATTERN_HIGH: pat_bytes[127:64] = data;
      wbps_pkg::REG_CARE_MASK: care_bits = data[15:0];
      wbps_pkg::REG_PATTERN_LENGTH: pat_len = data[wbps_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic program_pattern(input cfg_set_t c);
    drain_results();
    cfg_write(wbps_pkg::REG_PATTERN_LOW, c.lo);
    cfg_write(REG_UNUSED, {$urandom, $urandom});
    cfg_write(wbps_pkg::REG_PATTERN_HIGH, c.hi);
    cfg_write(wbps_pkg::REG_CARE_MASK, c.care);
    cfg_write(wbps_pkg::REG_PATTERN_LENGTH, c.len);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic fixed = 1'b0,
                           input wbps_pkg::out_item_t want = '0);
    wbps_pkg::out_item_t predicted;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{data_byte: b, region_end: last};
    do @(posedge clk); while (!in_ready);
    predicted = scan_byte('{data_byte: b, region_end: last});
    if (fixed) predicted = want;
    expected_matches.insert(expected_matches.size(), predicted);
  endtask

  task automatic random_phase(input int phase_no);
    cfg_set_t c;
    int len;
    int emit_len;
    int sent;
    int quota;
    int k;
    logic [7:0] b;
    c.lo = {$urandom, $urandom};
    c.hi = {$urandom, $urandom};
    c.care = {$urandom, $urandom};
    c.len = {$urandom, $urandom};
    len = ($urandom_range(9) < 8) ? $urandom_range(1, 16) : $urandom_range(0, 31);
    c.care[15:0] = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
    case (phase_no)
      0: begin
        c.lo = '1;
        c.hi = '0;
        c.care[15:0] = 16'hFFFF;
        len = 16;
      end
      1: begin
        c.care[15:0] = 16'h0000;
        len = 16;
      end
      2: len = 31;
      3: len = 0;
      4: len = 1;
      default: ;
    endcase
    c.len[wbps_pkg::LEN_W-1:0] = len[wbps_pkg::LEN_W-1:0];
    program_pattern(c);
    if (phase_no == 5) stall_requests <= stall_requests + 1;
    no_idle <= (phase_no == 6);
    quota = $urandom_range(50, 75);
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(9) < 6) begin
        emit_len = (len >= 1 && len <= 16) ? len : $urandom_range(1, 16);
        k = ($urandom_range(5) == 0) ? $urandom_range(0, emit_len - 1) : -1;
        for (int j = 0; j < emit_len; j++) begin
          b = pat_bytes[8*j +: 8];
          if (!care_bits[j]) b = 8'($urandom);
          if (j == k) b = b ^ 8'($urandom_range(1, 255));
          send_byte(b, $urandom_range(39) == 0);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          b = $urandom_range(1) ? 8'($urandom) : pat_bytes[8*$urandom_range(0, 15) +: 8];
          send_byte(b, $urandom_range(39) == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (stall_requests != stalls_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stalls_served++;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_results
    wbps_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        $error("result with no item pending: %p", out_item);
        failures++;
      end else begin
        want = expected_matches.pop_front();
        if (out_item.match_found !== want.match_found) begin
          $error("match_found: expected %0d, got %0d", want.match_found, out_item.match_found);
          failures++;
        end
        if (out_item.match_offset !== want.match_offset) begin
          $error("match_offset: expected %0d, got %0d",
                 want.match_offset, out_item.match_offset);
          failures++;
        end
        if (out_item.region_done !== want.region_done) begin
          $error("region_done: expected %0d, got %0d", want.region_done, out_item.region_done);
          failures++;
        end
      end
    end
  end

  initial begin : stimulus
    int cur_cfg;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cur_cfg = CFG_RESET;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].cfg_sel != cur_cfg) begin
        cur_cfg = directed_rows[r].cfg_sel;
        program_pattern(directed_cfgs[cur_cfg]);
      end
      send_byte(directed_rows[r].data, directed_rows[r].last,
                directed_rows[r].fixed, directed_rows[r].want);
    end
    for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);
    drain_results();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("wildcard_byte_pattern_search_tb OK");
    end else begin
      $display("wildcard_byte_pattern_search_tb NOT OK");
    end
    $finish;
  end

endmodule
